// File: rtl/core/two_class_age_ordered_queue_core_assert.svh
// Assertion macros shared by the two-class age-ordered queue RTL.
`ifndef TWO_CLASS_AGE_ORDERED_QUEUE_CORE_ASSERT_SVH
`define TWO_CLASS_AGE_ORDERED_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked at every rising edge outside reset.
`define TCQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("tcq assertion failed");
// Property checked at every rising edge, reset included.
`define TCQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("tcq assertion failed");
`else
`define TCQ_ASSERT(label, clk, rstn, prop)
`define TCQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/core/tcq_pkg.sv
// Types, codes and defaults of the two-class age-ordered queue.
`default_nettype none
package tcq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 16;
    localparam int DEF_STAMP_WIDTH = 32;

    localparam int IN_ID_W  = 16;
    localparam int OUT_ID_W = 16;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_ANY = 2'd1;
    localparam logic [1:0] FUNC_DOG = 2'd2;
    localparam logic [1:0] FUNC_CAT = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic KIND_DOG = 1'b0;
    localparam logic KIND_CAT = 1'b1;

    typedef struct packed {
        logic [1:0]          func;
        logic                kind;
        logic [IN_ID_W-1:0]  item_id;
    } tcq_in_t;

    typedef struct packed {
        logic [OUT_ID_W-1:0] out_id;
        logic                out_kind;
        logic [1:0]          status;
        logic                dog_empty;
        logic                cat_empty;
        logic                all_empty;
    } tcq_out_t;

    // Per-queue commands from the top level.
    typedef struct packed {
        logic push;
        logic read;
        logic pop;
    } tcq_fifo_ctrl_t;

    // Per-queue occupancy flags.
    typedef struct packed {
        logic empty;
        logic one;
        logic full;
    } tcq_fifo_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/tcq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/tcq_fifo.sv
// One class queue: head and fill pointers around a RAM of ids and stamps.
`default_nettype none
`include "two_class_age_ordered_queue_core_assert.svh"
module tcq_fifo #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16,
    parameter int STAMP_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire tcq_pkg::tcq_fifo_ctrl_t    ctrl,
    input  wire logic [ID_WIDTH-1:0]        wr_id,
    input  wire logic [STAMP_WIDTH-1:0]     wr_stamp,
    output logic      [ID_WIDTH-1:0]        rd_id,
    output logic      [STAMP_WIDTH-1:0]     rd_stamp,
    output tcq_pkg::tcq_fifo_stat_t         stat
);
    import tcq_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = $clog2(2 * QUEUE_DEPTH);
    localparam int WORD_W = ID_WIDTH + STAMP_WIDTH;

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [WORD_W-1:0] rd_word;

    // Tail sits below twice the depth: one compare and subtract wraps it.
    always_comb begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            tail = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
        end else begin
            tail = PTR_W'(tail_sum);
        end
    end

    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ctrl.push) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (ctrl.pop) begin
            fill_next = fill_reg - FILL_W'(1);
            if (head_reg == PTR_W'(QUEUE_DEPTH - 1)) begin
                head_next = '0;
            end else begin
                head_next = head_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    tcq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ctrl.push),
        .wr_addr (tail),
        .wr_data ({wr_id, wr_stamp}),
        .rd_en   (ctrl.read),
        .rd_addr (head_reg),
        .rd_data (rd_word)
    );

    assign rd_id    = rd_word[WORD_W-1:STAMP_WIDTH];
    assign rd_stamp = rd_word[STAMP_WIDTH-1:0];

    assign stat.empty = (fill_reg == '0);
    assign stat.one   = (fill_reg == FILL_W'(1));
    assign stat.full  = (fill_reg == FILL_W'(QUEUE_DEPTH));

    `TCQ_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FILL_W'(QUEUE_DEPTH))
    `TCQ_ASSERT(a_push_not_full, aclk, aresetn, ctrl.push |-> !stat.full)
    `TCQ_ASSERT(a_pop_moves_fill, aclk, aresetn,
        (ctrl.pop && !ctrl.push) |=> fill_reg == $past(fill_reg) - FILL_W'(1))

endmodule
`default_nettype wire

// File: rtl/core/two_class_age_ordered_queue_core.sv
// Top level of the two-class age-ordered queue: request control and result register.
`default_nettype none
`include "two_class_age_ordered_queue_core_assert.svh"
// Each item passes an accept step (RAM write or head read) and a commit step that
//   uses the registered head data and moves the pointers; the result is registered at
//   commit. No new item is taken until the commit.
// A stalled output holds the commit cycle until the result register frees.
// Reset (aresetn low, synchronous): both queues empty, arrival counter zero,
//   no result pending. RAM contents are not cleared; no clearing pass.
module two_class_age_ordered_queue_core #(
    parameter int QUEUE_DEPTH = tcq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = tcq_pkg::DEF_ID_WIDTH,
    parameter int STAMP_WIDTH = tcq_pkg::DEF_STAMP_WIDTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire tcq_pkg::tcq_in_t s_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output tcq_pkg::tcq_out_t     m_item
);
    import tcq_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_WORK = 1'b1;

    // Control state.
    logic [0:0]             state_reg, state_next;
    logic [STAMP_WIDTH-1:0] stamp_reg, stamp_next;
    logic                   m_valid_reg, m_valid_next;

    // Request held from accept to commit.
    tcq_in_t  req_reg;
    logic     add_full_reg;
    tcq_out_t m_item_reg, m_item_next;

    logic accept;
    logic commit;
    logic add_ok;
    logic add_full;

    tcq_fifo_ctrl_t dog_ctrl, cat_ctrl;
    tcq_fifo_stat_t dog_stat, cat_stat;
    logic [ID_WIDTH-1:0]    wr_id;
    logic [ID_WIDTH-1:0]    dog_id, cat_id;
    logic [STAMP_WIDTH-1:0] dog_stamp, cat_stamp;
    logic [STAMP_WIDTH-1:0] stamp_diff;

    logic pop_dog, pop_cat;

    // ------------------------------------------------------------------
    // Accept side: one item at a time; a finished result may still wait
    // in the output register while the next item is taken.
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == ST_WORK) && (!m_valid_reg || m_ready);

    // Full check of the target class at accept time.
    assign add_full = (s_item.kind == KIND_CAT) ? cat_stat.full : dog_stat.full;
    assign add_ok   = accept && (s_item.func == FUNC_ADD) && !add_full;
    assign wr_id    = ID_WIDTH'(s_item.item_id);

    // Write the tail on an accepted add that found room, read both heads on every accept, pop at commit.
    always_comb begin
        dog_ctrl.push = add_ok && (s_item.kind == KIND_DOG);
        dog_ctrl.read = accept;
        dog_ctrl.pop  = pop_dog;
        cat_ctrl.push = add_ok && (s_item.kind == KIND_CAT);
        cat_ctrl.read = accept;
        cat_ctrl.pop  = pop_cat;
    end

    tcq_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_dog (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (dog_ctrl),
        .wr_id    (wr_id),
        .wr_stamp (stamp_reg),
        .rd_id    (dog_id),
        .rd_stamp (dog_stamp),
        .stat     (dog_stat)
    );

    tcq_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_cat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (cat_ctrl),
        .wr_id    (wr_id),
        .wr_stamp (stamp_reg),
        .rd_id    (cat_id),
        .rd_stamp (cat_stamp),
        .stat     (cat_stat)
    );

    // Modular age compare: dog is older when dog minus cat is negative.
    assign stamp_diff = dog_stamp - cat_stamp;

    // ------------------------------------------------------------------
    // Commit: pick the queue, form the result, report flags after the pop.
    // Pointers only move here or at accept, and the two never overlap, so
    // the head data read at accept is still current.
    // ------------------------------------------------------------------
    always_comb begin
        logic pick_dog;
        logic pick_cat;
        logic dog_empty_after;
        logic cat_empty_after;

        pick_dog = 1'b0;
        pick_cat = 1'b0;
        unique case (req_reg.func)
            FUNC_ADD: begin
                pick_dog = 1'b0;
            end
            FUNC_DOG: begin
                pick_dog = !dog_stat.empty;
            end
            FUNC_CAT: begin
                pick_cat = !cat_stat.empty;
            end
            FUNC_ANY: begin
                priority if (!dog_stat.empty && !cat_stat.empty) begin
                    pick_dog = stamp_diff[STAMP_WIDTH-1];
                    pick_cat = !stamp_diff[STAMP_WIDTH-1];
                end else if (!dog_stat.empty) begin
                    pick_dog = 1'b1;
                end else begin
                    pick_cat = !cat_stat.empty;
                end
            end
            default: begin
                pick_dog = 1'b0;
            end
        endcase

        pop_dog = commit && pick_dog;
        pop_cat = commit && pick_cat;

        dog_empty_after = pick_dog ? dog_stat.one : dog_stat.empty;
        cat_empty_after = pick_cat ? cat_stat.one : cat_stat.empty;

        m_item_next.out_id    = '0;
        m_item_next.out_kind  = KIND_DOG;
        m_item_next.status    = STATUS_OK;
        m_item_next.dog_empty = dog_empty_after;
        m_item_next.cat_empty = cat_empty_after;
        m_item_next.all_empty = dog_empty_after && cat_empty_after;

        if (req_reg.func == FUNC_ADD) begin
            m_item_next.status = add_full_reg ? STATUS_FULL : STATUS_OK;
        end else if (pick_dog) begin
            m_item_next.out_id = OUT_ID_W'(dog_id);
        end else if (pick_cat) begin
            m_item_next.out_id   = OUT_ID_W'(cat_id);
            m_item_next.out_kind = KIND_CAT;
        end else begin
            m_item_next.status = STATUS_EMPTY;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, arrival counter and result valid.
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        stamp_next   = stamp_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                if (commit) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance the stamp only on an add that found room.
        if (add_ok) begin
            stamp_next = stamp_reg + STAMP_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stamp_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stamp_reg   <= stamp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: hold request until commit, result until taken.
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg      <= s_item;
            add_full_reg <= add_full;
        end
        if (commit) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `TCQ_ASSERT(a_one_pop, aclk, aresetn, $onehot0({pop_dog, pop_cat}))
    `TCQ_ASSERT(a_pop_has_entry, aclk, aresetn,
        (!pop_dog || !dog_stat.empty) && (!pop_cat || !cat_stat.empty))
    `TCQ_ASSERT(a_stamp_holds, aclk, aresetn, !add_ok |=> $stable(stamp_reg))
    `TCQ_ASSERT(a_accept_to_work, aclk, aresetn, accept |=> state_reg == ST_WORK)

endmodule
`default_nettype wire

// File: dv/two_class_age_ordered_queue_core_test.sv
// Self-checking testbench for the two-class age-ordered queue core.
`timescale 1ns / 100ps
module two_class_age_ordered_queue_core_test;
    import tcq_pkg::*;

    localparam int DEPTH         = tcq_pkg::DEF_QUEUE_DEPTH;
    localparam int RANDOM_ITEMS  = 850;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_START    = 140;     // receiver cycle where the long hold begins
    localparam int HOLD_CYCLES   = 160;
    localparam int CALM_FIRST    = 400;     // random items sent with no idling on either side
    localparam int CALM_LAST     = 549;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_REPORTS   = 50;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    tcq_in_t  s_item;
    logic     m_valid;
    logic     m_ready;
    tcq_out_t m_item;

    logic        calm;
    int unsigned cycle_count;

    // Mirror of both class queues; holds the responses still owed by the core.
    class pet_queue_mirror;
        logic [IN_ID_W-1:0] ids    [2][DEPTH];
        logic [31:0]        stamps [2][DEPTH];
        int unsigned        head   [2];
        int unsigned        fill   [2];
        logic [31:0]        arrivals;
        tcq_out_t           owed_responses [$];
        int unsigned        errors;

        function new();
            head     = '{0, 0};
            fill     = '{0, 0};
            arrivals = '0;
            errors   = 0;
        endfunction

        // Apply one accepted request and queue the response it must produce.
        function void note_request(tcq_in_t req);
            tcq_out_t    rsp;
            int          pick;
            int          k;
            int unsigned tail;
            logic [31:0] gap;
            rsp  = '0;
            pick = -1;
            rsp.status = STATUS_OK;
            if (req.func == FUNC_ADD) begin
                k = (req.kind == KIND_CAT) ? 1 : 0;
                if (fill[k] >= DEPTH) begin
                    rsp.status = STATUS_FULL;
                end else begin
                    tail = (head[k] + fill[k]) % DEPTH;
                    ids[k][tail]    = req.item_id;
                    stamps[k][tail] = arrivals;
                    fill[k]++;
                    arrivals = arrivals + 32'd1;
                end
            end else begin
                if (req.func == FUNC_DOG) begin
                    pick = (fill[0] != 0) ? 0 : -1;
                end else if (req.func == FUNC_CAT) begin
                    pick = (fill[1] != 0) ? 1 : -1;
                end else if (fill[0] != 0 && fill[1] != 0) begin
                    // Dog wins only when its stamp is strictly older, modulo wrap.
                    gap  = stamps[0][head[0]] - stamps[1][head[1]];
                    pick = gap[31] ? 0 : 1;
                end else if (fill[0] != 0) begin
                    pick = 0;
                end else if (fill[1] != 0) begin
                    pick = 1;
                end
                if (pick < 0) begin
                    rsp.status = STATUS_EMPTY;
                end else begin
                    rsp.out_id   = ids[pick][head[pick]];
                    rsp.out_kind = (pick == 1) ? KIND_CAT : KIND_DOG;
                    head[pick]   = (head[pick] + 1) % DEPTH;
                    fill[pick]--;
                end
            end
            rsp.dog_empty = (fill[0] == 0);
            rsp.cat_empty = (fill[1] == 0);
            rsp.all_empty = (fill[0] == 0) && (fill[1] == 0);
            owed_responses.push_back(rsp);
        endfunction

        function void report_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted response with the oldest one owed.
        function void check_response(tcq_out_t got);
            tcq_out_t want;
            if (owed_responses.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected response, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = owed_responses.pop_front();
                report_field("out_id",    want.out_id,    got.out_id);
                report_field("out_kind",  want.out_kind,  got.out_kind);
                report_field("status",    want.status,    got.status);
                report_field("dog_empty", want.dog_empty, got.dog_empty);
                report_field("cat_empty", want.cat_empty, got.cat_empty);
                report_field("all_empty", want.all_empty, got.all_empty);
            end
        endfunction
    endclass

    pet_queue_mirror mirror = new();

    two_class_age_ordered_queue_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Free-running clock, 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offer one request, with random idle cycles ahead of it unless calm.
    // Enter and leave at a falling edge so every drive lands mid-cycle.
    task automatic send_request(input logic [1:0] func, input logic kind,
                                input logic [IN_ID_W-1:0] id);
        tcq_in_t req;
        req.func    = func;
        req.kind    = kind;
        req.item_id = id;
        while (!calm && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_item  <= req;
        s_valid <= 1'b1;
        // Hold the item until the core takes it.
        do @(posedge aclk); while (!s_ready);
        mirror.note_request(req);
        @(negedge aclk);
    endtask

    // Stimulus: directed corner cases, then phases of random traffic.
    initial begin
        int unsigned       add_weight;
        int unsigned       cat_weight;
        int unsigned       pick;
        logic [1:0]        func;
        logic [IN_ID_W-1:0] id;
        s_valid = 1'b0;
        s_item  = '0;
        aresetn = 1'b0;
        calm    = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Poll every class while both queues are empty.
        send_request(FUNC_ANY, KIND_DOG, '0);
        send_request(FUNC_DOG, KIND_CAT, '1);
        send_request(FUNC_CAT, KIND_DOG, '0);
        // Extreme identifiers, then oldest-first order across classes.
        send_request(FUNC_ADD, KIND_DOG, '0);
        send_request(FUNC_ADD, KIND_CAT, '1);
        send_request(FUNC_ANY, KIND_CAT, '0);
        send_request(FUNC_ANY, KIND_DOG, '1);
        // Fill the cat queue and push once more into the full queue.
        for (int i = 0; i <= DEPTH; i++)
            send_request(FUNC_ADD, KIND_CAT, 16'hA5A5 ^ 16'(i));

        // Random traffic; the add weight shifts per phase so queues fill and drain.
        add_weight = 50;
        cat_weight = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                pick = $urandom_range(3);
                add_weight = (pick == 0) ? 85 : (pick == 1) ? 60 : (pick == 2) ? 35 : 15;
                cat_weight = $urandom_range(85, 15);
            end
            calm = (n >= CALM_FIRST && n <= CALM_LAST);
            if ($urandom_range(99) < add_weight) begin
                func = FUNC_ADD;
            end else begin
                pick = $urandom_range(3);
                func = (pick < 2) ? FUNC_ANY : (pick == 2) ? FUNC_DOG : FUNC_CAT;
            end
            pick = $urandom_range(9);
            id   = (pick == 0) ? '0 : (pick == 1) ? '1 : IN_ID_W'($urandom);
            send_request(func, ($urandom_range(99) < cat_weight) ? KIND_CAT : KIND_DOG, id);
        end
        calm    = 1'b0;
        s_valid <= 1'b0;

        // Drain what the core still owes, then allow a few quiet cycles.
        while (mirror.owed_responses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mirror.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Receiver: random back-pressure, one long hold to fill the core, none while calm.
    initial begin
        int unsigned rx_cycle;
        rx_cycle = 0;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
                m_ready <= 1'b0;
            else if (calm)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(99) >= 31);
        end
    end

    // Check every accepted response at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            mirror.check_response(m_item);
    end

    // Watchdog: end the run if it never drains.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tcq_pkg.sv
rtl/core/tcq_ram.sv
rtl/core/tcq_fifo.sv
rtl/core/two_class_age_ordered_queue_core.sv
dv/two_class_age_ordered_queue_core_test.sv
